FILE: rtl/hsv_to_rgb_converter_macros.svh
// assertion macros shared by the hsv to rgb checker
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// property checked only while out of reset
`define HSV_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define HSV_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/hsv_pkg.sv
// shared types and constants for the hsv to rgb converter
`timescale 1ns / 1ps
`default_nettype none

package hsv_pkg;

  // number of hue sectors in one full turn
  localparam int unsigned NUM_SECTORS = 6;

  // hue sector, named after the colors it runs between
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } hsv_sector_e;

  // control that travels with each word down the pipeline
  typedef struct packed {
    hsv_sector_e sector;
    logic        sat_zero;
  } hsv_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/hsv_sector.sv
// first stage: clamp inputs, split hue*6 into sector and fraction
`timescale 1ns / 1ps
`default_nettype none

module hsv_sector #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [FRAC_BITS:0]      hue_i,
  input  wire logic [FRAC_BITS:0]      saturation_i,
  input  wire logic [FRAC_BITS:0]      brightness_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output hsv_pkg::hsv_ctrl_t           ctrl_o,
  output logic [FRAC_BITS:0]           sat_o,
  output logic [FRAC_BITS:0]           val_o,
  output logic [FRAC_BITS-1:0]         frac_o,
  output logic [FRAC_BITS:0]           frac_inv_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [3:0] SECTORS = 4'(hsv_pkg::NUM_SECTORS);

  logic [W+2:0]          hue6;
  logic [3:0]            int_part;
  logic [3:0]            sector_wrap;
  logic [W-1:0]          sat_clamp;
  logic [W-1:0]          val_clamp;
  logic                  valid_q;
  hsv_pkg::hsv_ctrl_t    ctrl_d, ctrl_q;
  logic [W-1:0]          sat_q, val_q;
  logic [FRAC_BITS-1:0]  frac_q;
  logic [W-1:0]          frac_inv_d, frac_inv_q;

  // hue times six as 4h + 2h
  assign hue6 = {1'b0, hue_i, 2'b00} + {2'b00, hue_i, 1'b0};

  // integer part stays below twelve, so one subtract wraps it
  assign int_part    = hue6[W+2:FRAC_BITS];
  assign sector_wrap = (int_part >= SECTORS) ? (int_part - SECTORS) : int_part;

  // saturate to one
  assign sat_clamp = (saturation_i > ONE) ? ONE : saturation_i;
  assign val_clamp = (brightness_i > ONE) ? ONE : brightness_i;

  // sector, then the zero saturation flag
  assign ctrl_d     = {hsv_pkg::hsv_sector_e'(sector_wrap[2:0]), (saturation_i == '0)};
  assign frac_inv_d = ONE - {1'b0, hue6[FRAC_BITS-1:0]};

  // stage handshake
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ctrl_q     <= ctrl_d;
      sat_q      <= sat_clamp;
      val_q      <= val_clamp;
      frac_q     <= hue6[FRAC_BITS-1:0];
      frac_inv_q <= frac_inv_d;
    end
  end

  assign out_valid_o = valid_q;
  assign ctrl_o      = ctrl_q;
  assign sat_o       = sat_q;
  assign val_o       = val_q;
  assign frac_o      = frac_q;
  assign frac_inv_o  = frac_inv_q;

endmodule

`default_nettype wire

FILE: rtl/hsv_scale.sv
// second and third stages: saturation products, then value products p, q, t
`timescale 1ns / 1ps
`default_nettype none

module hsv_scale #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire hsv_pkg::hsv_ctrl_t      ctrl_i,
  input  wire logic [FRAC_BITS:0]      sat_i,
  input  wire logic [FRAC_BITS:0]      val_i,
  input  wire logic [FRAC_BITS-1:0]    frac_i,
  input  wire logic [FRAC_BITS:0]      frac_inv_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output hsv_pkg::hsv_ctrl_t           ctrl_o,
  output logic [FRAC_BITS:0]           val_o,
  output logic [FRAC_BITS:0]           p_o,
  output logic [FRAC_BITS:0]           q_o,
  output logic [FRAC_BITS:0]           t_o
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [2*W-1:0]      sf_prod, sfi_prod;
  logic [2*W-1:0]      p_prod, q_prod, t_prod;
  logic                s2_ready, s2_valid_q, s3_valid_q;
  hsv_pkg::hsv_ctrl_t  s2_ctrl_q, s3_ctrl_q;
  logic [W-1:0]        s2_val_q, s2_ks_q, s2_kq_q, s2_kt_q;
  logic [W-1:0]        s3_val_q, s3_p_q, s3_q_q, s3_t_q;

  // s*f and s*(1-f), truncated back to the fixed-point grid
  assign sf_prod  = sat_i * {1'b0, frac_i};
  assign sfi_prod = sat_i * frac_inv_i;

  // stage two handshake
  assign in_ready_o = !s2_valid_q || s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s2_valid_q <= in_valid_i;
    end
  end

  // stage two payload: the three factors that scale the value
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s2_ctrl_q <= ctrl_i;
      s2_val_q  <= val_i;
      s2_ks_q   <= ONE - sat_i;
      s2_kq_q   <= ONE - sf_prod[FRAC_BITS +: W];
      s2_kt_q   <= ONE - sfi_prod[FRAC_BITS +: W];
    end
  end

  // v times each factor, truncated
  assign p_prod = s2_val_q * s2_ks_q;
  assign q_prod = s2_val_q * s2_kq_q;
  assign t_prod = s2_val_q * s2_kt_q;

  // stage three handshake
  assign s2_ready = !s3_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  // stage three payload
  always_ff @(posedge clk_i) begin
    if (s2_ready && s2_valid_q) begin
      s3_ctrl_q <= s2_ctrl_q;
      s3_val_q  <= s2_val_q;
      s3_p_q    <= p_prod[FRAC_BITS +: W];
      s3_q_q    <= q_prod[FRAC_BITS +: W];
      s3_t_q    <= t_prod[FRAC_BITS +: W];
    end
  end

  assign out_valid_o = s3_valid_q;
  assign ctrl_o      = s3_ctrl_q;
  assign val_o       = s3_val_q;
  assign p_o         = s3_p_q;
  assign q_o         = s3_q_q;
  assign t_o         = s3_t_q;

endmodule

`default_nettype wire

FILE: rtl/hsv_route.sv
// last stage: route v, p, q, t to red, green, blue by sector into the output register
`timescale 1ns / 1ps
`default_nettype none

module hsv_route #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire hsv_pkg::hsv_ctrl_t      ctrl_i,
  input  wire logic [FRAC_BITS:0]      val_i,
  input  wire logic [FRAC_BITS:0]      p_i,
  input  wire logic [FRAC_BITS:0]      q_i,
  input  wire logic [FRAC_BITS:0]      t_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [FRAC_BITS:0]           red_o,
  output logic [FRAC_BITS:0]           green_o,
  output logic [FRAC_BITS:0]           blue_o
);

  localparam int unsigned W = FRAC_BITS + 1;

  logic [W-1:0] red_d, green_d, blue_d;
  logic [W-1:0] red_q, green_q, blue_q;
  logic         valid_q;

  // sector routing, grey when saturation is zero
  always_comb begin
    red_d   = val_i;
    green_d = val_i;
    blue_d  = val_i;
    if (!ctrl_i.sat_zero) begin
      unique case (ctrl_i.sector)
        hsv_pkg::SEC_RED_YEL: begin red_d = val_i; green_d = t_i;   blue_d = p_i;   end
        hsv_pkg::SEC_YEL_GRN: begin red_d = q_i;   green_d = val_i; blue_d = p_i;   end
        hsv_pkg::SEC_GRN_CYN: begin red_d = p_i;   green_d = val_i; blue_d = t_i;   end
        hsv_pkg::SEC_CYN_BLU: begin red_d = p_i;   green_d = q_i;   blue_d = val_i; end
        hsv_pkg::SEC_BLU_MAG: begin red_d = t_i;   green_d = p_i;   blue_d = val_i; end
        default:              begin red_d = val_i; green_d = p_i;   blue_d = q_i;   end
      endcase
    end
  end

  // output register handshake
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

`default_nettype wire

FILE: rtl/hsv_to_rgb_converter.sv
// top level of the hsv to rgb converter
// Converts one pixel per clock from hue, saturation and value in unsigned
// fixed point with FRAC_BITS fractional bits (1.0 is 2^FRAC_BITS) to red,
// green and blue in the same format. On the way from input to output,
// one register stage splits hue*6 into sector and fraction, two
// stages form the truncated products for p, q and t (saturation products,
// then value products), and the output register routes them by sector.
// A new word is taken every cycle; each stage moves on as soon as the next
// one has room, so a stall at the output fills the stages behind it before
// the input is held off. Saturation and value above 1.0 are clamped, hue of
// a full turn or more wraps around, and zero saturation gives grey.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // hue, saturation, brightness, zero pad
  input  wire logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0]   s_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // red, green, blue, zero pad
  output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0]        m_axis_tdata
);

  localparam int unsigned W      = FRAC_BITS + 1;
  localparam int unsigned DATA_W = ((3 * W + 7) / 8) * 8;

  logic                  s1_valid, s1_ready;
  hsv_pkg::hsv_ctrl_t    s1_ctrl;
  logic [W-1:0]          s1_sat, s1_val, s1_frac_inv;
  logic [FRAC_BITS-1:0]  s1_frac;
  logic                  s3_valid, s3_ready;
  hsv_pkg::hsv_ctrl_t    s3_ctrl;
  logic [W-1:0]          s3_val, s3_p, s3_q, s3_t;
  logic [W-1:0]          red, green, blue;

  // sector and fraction
  hsv_sector #(.FRAC_BITS(FRAC_BITS)) u_sector (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .hue_i        (s_axis_tdata[0 +: W]),
    .saturation_i (s_axis_tdata[W +: W]),
    .brightness_i (s_axis_tdata[2*W +: W]),
    .out_valid_o  (s1_valid),
    .out_ready_i  (s1_ready),
    .ctrl_o       (s1_ctrl),
    .sat_o        (s1_sat),
    .val_o        (s1_val),
    .frac_o       (s1_frac),
    .frac_inv_o   (s1_frac_inv)
  );

  // p, q, t products
  hsv_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (s1_ready),
    .ctrl_i      (s1_ctrl),
    .sat_i       (s1_sat),
    .val_i       (s1_val),
    .frac_i      (s1_frac),
    .frac_inv_i  (s1_frac_inv),
    .out_valid_o (s3_valid),
    .out_ready_i (s3_ready),
    .ctrl_o      (s3_ctrl),
    .val_o       (s3_val),
    .p_o         (s3_p),
    .q_o         (s3_q),
    .t_o         (s3_t)
  );

  // sector routing and output register
  hsv_route #(.FRAC_BITS(FRAC_BITS)) u_route (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s3_valid),
    .in_ready_o  (s3_ready),
    .ctrl_i      (s3_ctrl),
    .val_i       (s3_val),
    .p_i         (s3_p),
    .q_i         (s3_q),
    .t_i         (s3_t),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  // pack the output word, zero filled to whole bytes
  assign m_axis_tdata = DATA_W'({blue, green, red});

endmodule

`default_nettype wire

FILE: rtl/hsv_checker.sv
// port-level checker for the hsv to rgb converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_converter_macros.svh"

module hsv_checker #(
  parameter int unsigned FRAC_BITS = 12
) (
  input wire logic                                   clk_i,
  input wire logic                                   rst_ni,
  input wire logic                                   s_axis_tready,
  input wire logic                                   m_axis_tvalid,
  input wire logic                                   m_axis_tready,
  input wire logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0]   m_axis_tdata
);

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic out_in_range;

  assign out_in_range = (m_axis_tdata[0 +: W] <= ONE) && (m_axis_tdata[W +: W] <= ONE)
                        && (m_axis_tdata[2*W +: W] <= ONE);

  // pipeline comes out of reset empty
  `HSV_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

  // a stalled output word holds
  `HSV_ASSERT(a_out_hold, clk_i, rst_ni,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "stalled output word changed")

  // every component stays within 0..1.0
  `HSV_ASSERT(a_out_range, clk_i, rst_ni, m_axis_tvalid |-> out_in_range,
    "output component above one")

  // with the output free, the whole pipeline moves and takes a new word
  `HSV_ASSERT(a_in_ready, clk_i, rst_ni, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready,
    "input held off with room at the output")

endmodule

bind hsv_to_rgb_converter hsv_checker #(.FRAC_BITS(FRAC_BITS)) u_hsv_checker (.*);

`default_nettype wire
